// ===== src/clt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_pkg: shared types for the cell linked list table
// Opcodes, status codes and the classified item carried from front to back.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int PIDX_MAX_W = 16;   // widest particle index (65536 particles)
    localparam int CELL_MAX_W = 20;   // widest cell index (1048576 cells)

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_MOVE   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_MOVED     = 3'd1,
        ST_UNCHANGED = 3'd2,
        ST_FILTERED  = 3'd3,
        ST_ABSENT    = 3'd4,
        ST_CLEARED   = 3'd5,
        ST_PRESENT   = 3'd6
    } status_t;

    typedef struct packed {
        op_t                   op;
        logic                  p_ok;     // index below the particle count
        logic [PIDX_MAX_W-1:0] pidx;
        logic [3:0]            ptype;
        logic [CELL_MAX_W-1:0] tcell;    // already saturated
    } item_t;

endpackage

// ===== src/cell_linked_list_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_linked_list_table: cell list kept as singly linked lists in RAM
// Clear, insert and move particles between per-cell lists, one status each.
//
//   channel   direction  tdata fields (low bit up)                tuser
//   s_        in         opcode, particle_index, particle_type,   -
//                        target_cell
//   m_        out        status, previous_cell                    -
//   cfg_      in         allowed_type (write only)                -
//
// Insert reads the particle's entry and pushes it on its cell's list; a move that
// relinks walks the links ahead of the particle in its old cell, one head/link
// RAM read per cycle, unlinks it and pushes it on the target list. Opcode 3 and
// an out-of-range index finish at once. Clear and the sweep after reset both
// visit max(MAX_CELLS, MAX_PARTICLES) addresses (4096 by default); no input is
// taken during the reset sweep.
// A two-entry queue holds input while the sequencer works or the output stalls.
// ----------------------------------------------------------------------------
module cell_linked_list_table #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_CELLS     = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,   // allowed_type
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // opcode, particle_index, particle_type, target_cell
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // status, previous_cell
);

    logic           q_valid, q_ready, init_busy;
    clt_pkg::item_t q_item;

    clt_front #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_CELLS(MAX_CELLS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .init_busy(init_busy),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    clt_back #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_CELLS(MAX_CELLS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .init_busy(init_busy),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

// ===== src/clt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module clt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/clt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_front: input acceptance and classification
// Unpacks each transaction, range-checks the index, saturates the cell and
// holds the result in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module clt_front #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_CELLS     = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [31:0]    s_tdata,
    input  logic           init_busy,
    output logic           q_valid,
    input  logic           q_ready,
    output clt_pkg::item_t q_item
);

    clt_pkg::item_t entries_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;
    clt_pkg::item_t cls;
    logic [31:0] idx_wide, cell_wide;

    always_comb begin
        idx_wide  = 32'(s_tdata[11:2]);
        cell_wide = 32'(s_tdata[27:16]);
        cls.op    = clt_pkg::op_t'(s_tdata[1:0]);
        cls.p_ok  = idx_wide < 32'(MAX_PARTICLES);
        cls.pidx  = clt_pkg::PIDX_MAX_W'(idx_wide);
        cls.ptype = s_tdata[15:12];
        if (cell_wide >= 32'(MAX_CELLS)) begin
            cls.tcell = clt_pkg::CELL_MAX_W'(MAX_CELLS - 1);
        end else begin
            cls.tcell = clt_pkg::CELL_MAX_W'(cell_wide);
        end
    end

    assign s_tready = (count_reg != 2'd2) && !init_busy;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = count_reg != 2'd0;
    assign pop      = q_valid && q_ready;
    assign q_item   = entries_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== src/clt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clt_back: list sequencer
// Sweeps the tables on reset and clear, pushes on insert, walks, unlinks and
// pushes on a move to a new cell, and registers one result per item.
// ----------------------------------------------------------------------------
module clt_back #(
    parameter int MAX_PARTICLES = 1024,
    parameter int MAX_CELLS     = 4096
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [4:0]     cfg_wdata,
    input  logic           q_valid,
    output logic           q_ready,
    input  clt_pkg::item_t q_item,
    output logic           init_busy,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata
);

    localparam int PW  = $clog2(MAX_PARTICLES);
    localparam int LW  = $clog2(MAX_PARTICLES + 1);
    localparam int CW  = $clog2(MAX_CELLS);
    localparam int SD  = (MAX_CELLS > MAX_PARTICLES) ? MAX_CELLS : MAX_PARTICLES;
    localparam int SW  = $clog2(SD);
    localparam int PIW = 1 + CW + LW;
    localparam logic [LW-1:0] MARK = LW'(MAX_PARTICLES);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SWEEP, S_CHKP, S_WALK_H, S_WALK_N, S_PUSH
    } state_t;

    state_t             state_reg, state_next;
    clt_pkg::item_t     item_reg, item_next;
    logic [SW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      old_reg, old_next;
    logic [LW-1:0]      pnext_reg, pnext_next;
    logic [PW-1:0]      prev_reg, prev_next;
    logic [LW-1:0]      steps_reg, steps_next;
    clt_pkg::status_t   st_reg, st_next;
    logic               out_valid_reg, out_valid_next;
    clt_pkg::status_t   out_status_reg, out_status_next;
    logic [11:0]        out_prev_reg, out_prev_next;
    logic [4:0]         allowed_reg;

    logic               head_we, head_re;
    logic [CW-1:0]      head_waddr, head_raddr;
    logic [LW-1:0]      head_wdata, head_rdata;
    logic               pi_we, pi_re;
    logic [PW-1:0]      pi_waddr, pi_raddr;
    logic [PIW-1:0]     pi_wdata, pi_rdata;

    logic               res_fire;
    clt_pkg::status_t   res_status;
    logic [11:0]        res_prev;
    logic [PW-1:0]      p;
    logic [CW-1:0]      tgt_cell;
    logic               d_in;
    logic [CW-1:0]      d_cell;
    logic [LW-1:0]      d_next;
    logic               filter_ok;

    clt_ram #(.WIDTH(LW), .DEPTH(MAX_CELLS)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(head_raddr), .rdata(head_rdata)
    );

    clt_ram #(.WIDTH(PIW), .DEPTH(MAX_PARTICLES)) u_pinfo (
        .aclk(aclk), .we(pi_we), .waddr(pi_waddr), .wdata(pi_wdata),
        .re(pi_re), .raddr(pi_raddr), .rdata(pi_rdata)
    );

    assign p         = PW'(item_reg.pidx);
    assign tgt_cell  = CW'(item_reg.tcell);
    assign d_in      = pi_rdata[PIW-1];
    assign d_cell    = pi_rdata[LW +: CW];
    assign d_next    = pi_rdata[LW-1:0];
    assign filter_ok = (allowed_reg == 5'b11111) || (allowed_reg == {1'b0, item_reg.ptype});

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        cnt_next   = cnt_reg;
        old_next   = old_reg;
        pnext_next = pnext_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        st_next    = st_reg;
        q_ready    = 1'b0;
        head_we    = 1'b0;
        head_waddr = tgt_cell;
        head_wdata = MARK;
        head_re    = 1'b0;
        head_raddr = tgt_cell;
        pi_we      = 1'b0;
        pi_waddr   = p;
        pi_wdata   = {1'b1, tgt_cell, head_rdata};
        pi_re      = 1'b0;
        pi_raddr   = p;
        res_fire   = 1'b0;
        res_status = clt_pkg::ST_ABSENT;
        res_prev   = 12'd0;

        case (state_reg)
            S_INIT, S_SWEEP: begin
                // clear every head and every membership bit
                head_waddr = CW'(cnt_reg);
                head_we    = 32'(cnt_reg) < 32'(MAX_CELLS);
                pi_waddr   = PW'(cnt_reg);
                pi_wdata   = '0;
                pi_we      = 32'(cnt_reg) < 32'(MAX_PARTICLES);
                cnt_next   = cnt_reg + SW'(1);
                if (32'(cnt_reg) == 32'(SD - 1)) begin
                    if (state_reg == S_SWEEP) begin
                        res_fire   = 1'b1;
                        res_status = clt_pkg::ST_CLEARED;
                    end
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid && !out_valid_reg) begin
                    q_ready   = 1'b1;
                    item_next = q_item;
                    pi_raddr  = PW'(q_item.pidx);
                    case (q_item.op)
                        clt_pkg::OP_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_SWEEP;
                        end
                        clt_pkg::OP_INSERT, clt_pkg::OP_MOVE: begin
                            if (q_item.p_ok) begin
                                pi_re      = 1'b1;
                                state_next = S_CHKP;
                            end else begin
                                res_fire = 1'b1;
                            end
                        end
                        default: begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            S_CHKP: begin
                state_next = S_IDLE;
                if (item_reg.op == clt_pkg::OP_INSERT) begin
                    if (d_in) begin
                        res_fire   = 1'b1;
                        res_status = clt_pkg::ST_PRESENT;
                    end else if (!filter_ok) begin
                        res_fire   = 1'b1;
                        res_status = clt_pkg::ST_FILTERED;
                    end else begin
                        head_re    = 1'b1;
                        st_next    = clt_pkg::ST_INSERTED;
                        state_next = S_PUSH;
                    end
                end else if (!d_in) begin
                    res_fire = 1'b1;
                end else if (d_cell == tgt_cell) begin
                    res_fire   = 1'b1;
                    res_status = clt_pkg::ST_UNCHANGED;
                    res_prev   = 12'(d_cell);
                end else begin
                    old_next   = d_cell;
                    pnext_next = d_next;
                    head_re    = 1'b1;
                    head_raddr = d_cell;
                    st_next    = clt_pkg::ST_MOVED;
                    state_next = S_WALK_H;
                end
            end
            S_WALK_H: begin
                if (head_rdata == LW'(p)) begin
                    head_we    = 1'b1;
                    head_waddr = old_reg;
                    head_wdata = pnext_reg;
                    head_re    = 1'b1;
                    state_next = S_PUSH;
                end else if (head_rdata >= MARK) begin
                    res_fire   = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    prev_next  = PW'(head_rdata);
                    pi_re      = 1'b1;
                    pi_raddr   = PW'(head_rdata);
                    steps_next = LW'(1);
                    state_next = S_WALK_N;
                end
            end
            S_WALK_N: begin
                if (d_next == LW'(p)) begin
                    // unlink: predecessor skips over the particle
                    pi_we      = 1'b1;
                    pi_waddr   = prev_reg;
                    pi_wdata   = {d_in, d_cell, pnext_reg};
                    head_re    = 1'b1;
                    state_next = S_PUSH;
                end else if (d_next >= MARK || steps_reg >= MARK) begin
                    res_fire   = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    prev_next  = PW'(d_next);
                    pi_re      = 1'b1;
                    pi_raddr   = PW'(d_next);
                    steps_next = steps_reg + LW'(1);
                end
            end
            S_PUSH: begin
                head_we    = 1'b1;
                head_wdata = LW'(p);
                pi_we      = 1'b1;
                res_fire   = 1'b1;
                res_status = st_reg;
                if (st_reg == clt_pkg::ST_MOVED) begin
                    res_prev = 12'(old_reg);
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next  = (out_valid_reg && !m_tready) || res_fire;
        out_status_next = res_fire ? res_status : out_status_reg;
        out_prev_next   = res_fire ? res_prev : out_prev_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            allowed_reg   <= 5'b11111;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                allowed_reg <= cfg_wdata;
            end
        end
        item_reg       <= item_next;
        old_reg        <= old_next;
        pnext_reg      <= pnext_next;
        prev_reg       <= prev_next;
        steps_reg      <= steps_next;
        st_reg         <= st_next;
        out_status_reg <= out_status_next;
        out_prev_reg   <= out_prev_next;
    end

    assign init_busy = state_reg == S_INIT;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_prev_reg, out_status_reg};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |-> !out_valid_reg)
        else $error("result produced while output register full");

    a_prev_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != clt_pkg::ST_MOVED
         && out_status_reg != clt_pkg::ST_UNCHANGED) |-> out_prev_reg == 12'd0)
        else $error("previous cell set on a status that carries none");

    a_head_link: assert property (@(posedge aclk) disable iff (!aresetn)
        head_we |-> head_wdata <= MARK)
        else $error("head written with an out-of-range link");

    a_take_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> (state_reg == S_IDLE && q_valid))
        else $error("item taken from queue while busy");

endmodule
